@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. They compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/imusfp_pkg.sv @@
package imusfp_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int SUM_BYTES   = 10;
    localparam int NUM_WORDS   = 14;
    localparam int FILL_W      = 4;
    localparam int IDX_W       = 4;
    localparam logic [7:0] HEADER_BYTE = 8'h55;

    // Register map, indexed by paddr[3:2].
    typedef enum logic [1:0] {
        REG_ACCEL = 2'd0,
        REG_GYRO  = 2'd1,
        REG_ANGLE = 2'd2,
        REG_QUAT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] accel_code;
        logic [7:0] gyro_code;
        logic [7:0] angle_code;
        logic [7:0] quat_code;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STRIP,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic push;
        logic drop;
        logic commit;
        logic load_word;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_empty;
        logic front_header;
        logic window_full;
        logic sum_ok;
        logic is_accel;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/imusfp_regs.sv @@
module imusfp_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output imusfp_pkg::cfg_t     cfg
);
    import imusfp_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                REG_ACCEL: cfg_next.accel_code = pwdata[7:0];
                REG_GYRO:  cfg_next.gyro_code  = pwdata[7:0];
                REG_ANGLE: cfg_next.angle_code = pwdata[7:0];
                REG_QUAT:  cfg_next.quat_code  = pwdata[7:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_code <= 8'd81;
            cfg_reg.gyro_code  <= 8'd82;
            cfg_reg.angle_code <= 8'd83;
            cfg_reg.quat_code  <= 8'd89;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (sel)
            REG_ACCEL: prdata = {24'd0, cfg_reg.accel_code};
            REG_GYRO:  prdata = {24'd0, cfg_reg.gyro_code};
            REG_ANGLE: prdata = {24'd0, cfg_reg.angle_code};
            REG_QUAT:  prdata = {24'd0, cfg_reg.quat_code};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/imusfp_dp.sv @@
module imusfp_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  imusfp_pkg::cfg_t         cfg,
    input  imusfp_pkg::dp_cmd_t      cmd,
    output imusfp_pkg::dp_status_t   status,
    input  logic [7:0]               rx_byte,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,
    output logic                     m_tlast,
    output logic [1:0]               m_tuser
);
    import imusfp_pkg::*;

    logic [7:0]        win_reg   [FRAME_BYTES];
    logic [7:0]        win_next  [FRAME_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       val_reg   [NUM_WORDS];
    logic [15:0]       val_next  [NUM_WORDS];
    logic              gyro_flag_reg, gyro_flag_next;
    logic              quat_flag_reg, quat_flag_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [15:0]       out_val_reg, out_val_next;
    logic              out_last_reg, out_last_next;
    logic [1:0]        out_user_reg, out_user_next;

    logic [7:0]  sum_lo, sum_hi, sum;
    logic [7:0]  frame_type;
    logic [15:0] word [4];
    logic        hit_accel, hit_gyro, hit_angle, hit_quat;

    // Checksum as two five-byte halves added at the end.
    assign sum_lo = win_reg[0] + win_reg[1] + win_reg[2] + win_reg[3] + win_reg[4];
    assign sum_hi = win_reg[5] + win_reg[6] + win_reg[7] + win_reg[8] + win_reg[9];
    assign sum    = sum_lo + sum_hi;

    assign frame_type = win_reg[1];
    assign hit_accel  = (frame_type == cfg.accel_code);
    assign hit_gyro   = (frame_type == cfg.gyro_code);
    assign hit_angle  = (frame_type == cfg.angle_code);
    assign hit_quat   = (frame_type == cfg.quat_code);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            word[k] = {win_reg[3 + 2 * k], win_reg[2 + 2 * k]};
        end
    end

    assign status.fill_empty   = (fill_reg == '0);
    assign status.front_header = (win_reg[0] == HEADER_BYTE);
    assign status.window_full  = (fill_reg == FILL_W'(FRAME_BYTES));
    assign status.sum_ok       = (sum == win_reg[SUM_BYTES]);
    assign status.is_accel     = hit_accel;
    assign status.emit_last    = (cnt_reg == IDX_W'(NUM_WORDS - 1));
    assign status.out_free     = !out_valid_reg || m_tready;

    always_comb begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        val_next       = val_reg;
        gyro_flag_next = gyro_flag_reg;
        quat_flag_next = quat_flag_reg;
        cnt_next       = cnt_reg;

        if (cmd.push) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (fill_reg == FILL_W'(i)) begin
                    win_next[i] = rx_byte;
                end
            end
            fill_next = fill_reg + 1'b1;
        end else if (cmd.drop) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            fill_next = fill_reg - 1'b1;
        end else if (cmd.commit) begin
            // Type codes may be equal; the first match in accel, gyro, angle,
            // quaternion order picks the slots to update.
            if (hit_accel) begin
                for (int k = 0; k < 4; k++) val_next[k] = word[k];
            end else if (hit_gyro) begin
                for (int k = 0; k < 3; k++) val_next[4 + k] = word[k];
                gyro_flag_next = 1'b1;
            end else if (hit_angle) begin
                for (int k = 0; k < 3; k++) val_next[7 + k] = word[k];
            end else if (hit_quat) begin
                for (int k = 0; k < 4; k++) val_next[10 + k] = word[k];
            end
            if (hit_quat) begin
                quat_flag_next = 1'b1;
            end
            fill_next = '0;
            cnt_next  = '0;
        end

        if (cmd.load_word) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        if (cmd.load_word) begin
            out_valid_next = 1'b1;
            out_idx_next   = cnt_reg;
            out_val_next   = val_reg[cnt_reg];
            out_last_next  = status.emit_last;
            out_user_next  = {quat_flag_reg, gyro_flag_reg};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            gyro_flag_reg <= 1'b0;
            quat_flag_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) val_reg[i] <= '0;
        end else begin
            fill_reg      <= fill_next;
            gyro_flag_reg <= gyro_flag_next;
            quat_flag_reg <= quat_flag_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            val_reg       <= val_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ hdl/imusfp_ctrl.sv @@
module imusfp_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  imusfp_pkg::dp_status_t   status,
    output imusfp_pkg::dp_cmd_t      cmd
);
    import imusfp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.push   = 1'b1;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                // Discard leading bytes until the window starts on a header.
                if (!status.fill_empty && !status.front_header) begin
                    cmd.drop = 1'b1;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_IDLE;
                if (status.window_full) begin
                    if (!status.sum_ok) begin
                        cmd.drop = 1'b1;
                    end else begin
                        cmd.commit = 1'b1;
                        if (status.is_accel) begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_word = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/imu_serial_frame_parser_top.sv @@
// Channel   Dir  Ports                           Payload
// s_        in   s_tvalid s_tready s_tdata[7:0]  one received byte per transfer
// m_        out  m_tvalid m_tready m_tdata ...   one stored raw word per transfer
// APB       in   psel penable pwrite paddr ...   four 8-bit frame type codes
//
// Each byte passes through the IDLE, STRIP and CHECK states; STRIP discards leading non-header bytes.
// A valid accel frame adds 14 word loads into the output register, one per
// cycle while m_tready keeps it free; a stalled output holds the loader.
// The last word may still wait in the output register while the next byte is taken.
// aresetn is synchronous; the byte window needs no clearing pass after reset.
`include "assert_macros.svh"

module imu_serial_frame_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] word_index, [19:4] word_value, [23:20] zero
    output logic        m_tlast,   // last_word
    output logic [1:0]  m_tuser,   // [0] gyro_seen, [1] quat_seen
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import imusfp_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    imusfp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    imusfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    imusfp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .rx_byte  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Between bytes the window never holds a complete frame.
    `ASSERT_IMPLY(a_idle_not_full, aclk, aresetn, s_tready, !status.window_full)
    // Loading the final word must raise tlast on the output register.
    `ASSERT_NEXT(a_last_flag, aclk, aresetn, cmd.load_word && status.emit_last, m_tlast && m_tvalid)
    // A consumed frame empties the window.
    `ASSERT_NEXT(a_commit_empties, aclk, aresetn, cmd.commit, status.fill_empty)

endmodule
